/* hdl/buzzer_pattern_with_alarm_override_macros.svh */
// Assertion helpers shared by the buzzer pattern RTL.
// Both macros sample on clk_i and are switched off while rst_ni is low.
`ifndef BUZZER_PATTERN_WITH_ALARM_OVERRIDE_MACROS_SVH
`define BUZZER_PATTERN_WITH_ALARM_OVERRIDE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPAO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPAO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bpao_pkg.sv */
`default_nettype none

package bpao_pkg;

  // Field widths of the words on both channels.
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned PERIOD_W = LEN_W + 1;
  localparam int unsigned PROD_W   = PERIOD_W + LEN_W;
  localparam int unsigned CFG_IDX_W = 2;

  // Default width of the saturating elapsed-time accumulators.
  localparam int unsigned ELAPSED_BITS_DEF = 48;

  // Reset values of the alarm pattern registers.
  localparam logic [LEN_W-1:0] ALARM_ON_RST     = 16'd500;
  localparam logic [LEN_W-1:0] ALARM_OFF_RST    = 16'd500;
  localparam logic [LEN_W-1:0] ALARM_REPEAT_RST = 16'd3;
  localparam logic [LEN_W-1:0] ALARM_FREQ_RST   = 16'd2000;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_HOST_CMD = 2'd1,
    OP_ALARM    = 2'd2,
    OP_UNUSED   = 2'd3
  } bpao_op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALARM_ON     = 2'd0,
    CFG_ALARM_OFF    = 2'd1,
    CFG_ALARM_REPEAT = 2'd2,
    CFG_ALARM_FREQ   = 2'd3
  } bpao_cfg_e;

  // Input word.
  typedef struct packed {
    logic [1:0]       operation;
    logic [NOW_W-1:0] now_ms;
    logic [LEN_W-1:0] cmd_on_ms;
    logic [LEN_W-1:0] cmd_off_ms;
    logic [LEN_W-1:0] cmd_repeat;
    logic [LEN_W-1:0] cmd_freq_hz;
  } bpao_in_t;

  // Output word.
  typedef struct packed {
    logic [LEN_W-1:0] tone_hz;
    logic             alarm_playing;
  } bpao_out_t;

  // Status returned by the remainder unit.
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [PERIOD_W-1:0] rem;
  } bpao_rem_rsp_t;

endpackage

`default_nettype wire

/* hdl/bpao_rem.sv */
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle, most significant first.
module bpao_rem
  import bpao_pkg::*;
#(
  parameter int unsigned ELAPSED_BITS = ELAPSED_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [ELAPSED_BITS-1:0] dividend_i,
  input  wire logic [PERIOD_W-1:0]     divisor_i,
  output bpao_rem_rsp_t                rsp_o
);

  localparam int unsigned CNT_W = $clog2(ELAPSED_BITS + 1);

  logic [ELAPSED_BITS-1:0] dvd_q;
  logic [PERIOD_W-1:0]     dvs_q;
  logic [PERIOD_W-1:0]     rem_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    done_q;
  logic [PERIOD_W:0]       trial;
  logic                    fits;
  logic [PERIOD_W-1:0]     rem_d;

  // Shift the next dividend bit in and subtract the divisor when it fits.
  assign trial = {rem_q, dvd_q[ELAPSED_BITS-1]};
  assign fits  = (trial >= {1'b0, dvs_q});
  always_comb begin
    if (fits) begin
      rem_d = PERIOD_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[PERIOD_W-1:0];
    end
  end

  // Step counter and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q <= dividend_i;
        dvs_q <= divisor_i;
        rem_q <= '0;
        cnt_q <= CNT_W'(ELAPSED_BITS);
      end else if (cnt_q != '0) begin
        dvd_q <= {dvd_q[ELAPSED_BITS-2:0], 1'b0};
        rem_q <= rem_d;
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = (cnt_q != '0);
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

/* hdl/buzzer_pattern_with_alarm_override.sv */
`default_nettype none

// Buzzer on/off tone pattern generator with a battery alarm override. Each input
// word is a tick carrying the millisecond time, a host pattern command, or an
// alarm trigger; only ticks produce an output word (tone and alarm flag).
// Commands and triggers are taken in the idle state, which the block does not leave
// for them. A tick goes through S_ACC, S_CHECK and S_MOD, where it waits for the
// remainder unit, and then S_OUT; when the alarm completes on that tick, the
// sequencer returns to S_ACC and evaluates the host pattern in its place. Silent,
// steady and finished patterns skip the phase calculation and so skip S_MOD.
// The shared remainder unit works out elapsed time modulo the pattern period
// one bit per cycle. A finished output word waits in its own register, so the next
// input word is taken before it is collected.
// Alarm registers may be written only while no tick is in progress.
module buzzer_pattern_with_alarm_override
  import bpao_pkg::*;
#(
  parameter int unsigned ELAPSED_BITS = ELAPSED_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire bpao_in_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output bpao_out_t                 out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LEN_W-1:0]     cfg_wdata_i
);

  `include "buzzer_pattern_with_alarm_override_macros.svh"

  localparam int unsigned EW = ELAPSED_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_CHECK,
    S_MOD,
    S_OUT
  } state_e;

  state_e state_q;

  // Alarm configuration.
  logic [LEN_W-1:0] alarm_on_q, alarm_off_q, alarm_repeat_q, alarm_freq_q;

  // Pattern state.
  logic [LEN_W-1:0] host_on_q, host_off_q, host_cycles_q, host_tone_q;
  logic [NOW_W-1:0] host_last_q, alarm_last_q;
  logic [EW-1:0]    host_elapsed_q, alarm_elapsed_q;
  logic             alarm_flag_q;

  // Tick in progress.
  logic                sel_alarm_q;
  logic [NOW_W-1:0]    now_q;
  logic [PERIOD_W-1:0] period_q;
  logic [PROD_W-1:0]   prod_q;
  bpao_out_t           res_q;
  bpao_out_t           out_q;
  logic                out_valid_q;

  // Selected pattern operands.
  logic [LEN_W-1:0] p_on, p_off, p_cyc, p_freq;
  logic [NOW_W-1:0] p_last;
  logic [EW-1:0]    p_elapsed;
  logic [NOW_W-1:0] diff;
  logic [EW:0]      sum;
  logic [EW-1:0]    acc_val;
  logic [PERIOD_W-1:0] period_d;
  logic                complete;
  logic                rem_start;
  logic                out_free;
  bpao_rem_rsp_t       rem_rsp;

  // The host pattern is silent when its tone is zero.
  always_comb begin
    if (sel_alarm_q) begin
      p_on      = alarm_on_q;
      p_off     = alarm_off_q;
      p_cyc     = alarm_repeat_q;
      p_freq    = alarm_freq_q;
      p_last    = alarm_last_q;
      p_elapsed = alarm_elapsed_q;
    end else begin
      p_on      = (host_tone_q == '0) ? '0 : host_on_q;
      p_off     = host_off_q;
      p_cyc     = host_cycles_q;
      p_freq    = host_tone_q;
      p_last    = host_last_q;
      p_elapsed = host_elapsed_q;
    end
  end

  // Saturating accumulation of the wrapping time difference.
  assign diff     = now_q - p_last;
  assign sum      = {1'b0, p_elapsed} + {{(EW + 1 - NOW_W){1'b0}}, diff};
  assign acc_val  = sum[EW] ? '1 : sum[EW-1:0];
  assign period_d = {1'b0, p_on} + {1'b0, p_off};

  // The pattern is complete once all its cycles have gone by.
  assign complete  = (p_cyc != '0) && (p_elapsed >= {{(EW - PROD_W){1'b0}}, prod_q});
  assign rem_start = (state_q == S_CHECK) && !complete;
  assign out_free  = !out_valid_q || out_ready_i;

  bpao_rem #(
    .ELAPSED_BITS(ELAPSED_BITS)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(p_elapsed),
    .divisor_i (period_q),
    .rsp_o     (rem_rsp)
  );

  // Sequencer, pattern state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      alarm_on_q      <= ALARM_ON_RST;
      alarm_off_q     <= ALARM_OFF_RST;
      alarm_repeat_q  <= ALARM_REPEAT_RST;
      alarm_freq_q    <= ALARM_FREQ_RST;
      host_on_q       <= '0;
      host_off_q      <= '0;
      host_cycles_q   <= '0;
      host_tone_q     <= '0;
      host_last_q     <= '0;
      host_elapsed_q  <= '0;
      alarm_last_q    <= '0;
      alarm_elapsed_q <= '0;
      alarm_flag_q    <= 1'b0;
      sel_alarm_q     <= 1'b0;
      now_q           <= '0;
      period_q        <= '0;
      prod_q          <= '0;
      res_q           <= '0;
      out_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ALARM_ON:     alarm_on_q     <= cfg_wdata_i;
          CFG_ALARM_OFF:    alarm_off_q    <= cfg_wdata_i;
          CFG_ALARM_REPEAT: alarm_repeat_q <= cfg_wdata_i;
          CFG_ALARM_FREQ:   alarm_freq_q   <= cfg_wdata_i;
          default: ;
        endcase
      end

      // A collected word leaves the output register unless a new one replaces it.
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            now_q <= in_data_i.now_ms;
            case (in_data_i.operation)
              OP_TICK: begin
                sel_alarm_q <= alarm_flag_q;
                state_q     <= S_ACC;
              end
              OP_HOST_CMD: begin
                host_on_q     <= in_data_i.cmd_on_ms;
                host_off_q    <= in_data_i.cmd_off_ms;
                host_cycles_q <= in_data_i.cmd_repeat;
                host_tone_q   <= in_data_i.cmd_freq_hz;
                if (!alarm_flag_q) begin
                  host_last_q    <= in_data_i.now_ms;
                  host_elapsed_q <= '0;
                end
              end
              OP_ALARM: begin
                alarm_flag_q    <= 1'b1;
                alarm_last_q    <= in_data_i.now_ms;
                alarm_elapsed_q <= '0;
              end
              default: ;
            endcase
          end
        end

        S_ACC: begin
          if (p_on == '0) begin
            if (sel_alarm_q) begin
              // Alarm done: restart the host pattern at this tick.
              alarm_flag_q   <= 1'b0;
              sel_alarm_q    <= 1'b0;
              host_last_q    <= now_q;
              host_elapsed_q <= '0;
            end else begin
              res_q   <= '0;
              state_q <= S_OUT;
            end
          end else if (p_off == '0) begin
            res_q.tone_hz       <= p_freq;
            res_q.alarm_playing <= sel_alarm_q;
            state_q             <= S_OUT;
          end else begin
            if (sel_alarm_q) begin
              alarm_last_q    <= now_q;
              alarm_elapsed_q <= acc_val;
            end else begin
              host_last_q    <= now_q;
              host_elapsed_q <= acc_val;
            end
            period_q <= period_d;
            prod_q   <= PROD_W'(period_d) * PROD_W'(p_cyc);
            state_q  <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (complete) begin
            if (sel_alarm_q) begin
              alarm_flag_q   <= 1'b0;
              sel_alarm_q    <= 1'b0;
              host_last_q    <= now_q;
              host_elapsed_q <= '0;
              state_q        <= S_ACC;
            end else begin
              res_q   <= '0;
              state_q <= S_OUT;
            end
          end else begin
            state_q <= S_MOD;
          end
        end

        S_MOD: begin
          if (rem_rsp.done) begin
            res_q.tone_hz       <= (rem_rsp.rem < {1'b0, p_on}) ? p_freq : '0;
            res_q.alarm_playing <= sel_alarm_q;
            state_q             <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A tick keeps the block busy for at least the following cycle.
  `BPAO_ASSERT_NEXT(a_tick_busy, in_valid_i && in_ready_o && (in_data_i.operation == OP_TICK), !in_ready_o, "tick accepted but block ready next cycle")
  // The remainder unit only finishes while the sequencer waits for it.
  `BPAO_ASSERT_NOW(a_rem_done_waited, rem_rsp.done, state_q == S_MOD, "remainder result arrived outside its wait state")
  // The remainder unit only works while the sequencer waits for it.
  `BPAO_ASSERT_NOW(a_rem_busy_waited, rem_rsp.busy, state_q == S_MOD, "remainder unit busy outside its wait state")
  // An alarm word is only produced while the alarm is still active.
  `BPAO_ASSERT_NOW(a_alarm_word_active, (state_q == S_OUT) && res_q.alarm_playing, alarm_flag_q, "alarm word produced with alarm inactive")
  // When the alarm ends, the host pattern restarts from zero at that tick.
  `BPAO_ASSERT_NOW(a_host_restart, $fell(alarm_flag_q), (host_elapsed_q == '0) && (host_last_q == now_q), "host pattern not restarted when alarm ended")

endmodule

`default_nettype wire
